// File: design/efrd_pkg.sv
// constants, types and the sweep cost function for the elevator dispatcher
// used by elevator_fastest_response_dispatch and its checker; no dependencies
`timescale 1ns / 1ps

package efrd_pkg;

	localparam int FLOORS      = 9;
	localparam int FLOOR_W     = 4;
	localparam int WEIGHT_W    = 4;
	localparam int C_W         = $clog2(FLOORS + 2);
	localparam int IDX_W       = $clog2(FLOORS);
	localparam int NO_WAY_COST = 360;
	localparam int COST_W      = $clog2(NO_WAY_COST + 1);
	localparam int PROD_W      = COST_W + WEIGHT_W;
	localparam int DEF_W       = 3;

	localparam logic [WEIGHT_W-1:0] KEEP_RESET = WEIGHT_W'(5);
	localparam logic [WEIGHT_W-1:0] TURN_RESET = WEIGHT_W'(6);
	localparam logic [C_W-1:0]      FLOOR_NONE = C_W'(FLOORS + 1);

	localparam logic CFG_KEEP = 1'b0;
	localparam logic CFG_TURN = 1'b1;

	typedef enum logic [1:0] {
		MODE_CAR     = 2'd0,
		MODE_HALL_UP = 2'd1,
		MODE_HALL_DN = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_MOVE  = 2'd0,
		ACT_SERVE = 2'd1,
		ACT_IDLE  = 2'd2
	} action_t;

	// call extents gathered by one scan over the floors
	typedef struct packed {
		logic [C_W-1:0] in_lo;
		logic [C_W-1:0] in_hi;
		logic [C_W-1:0] below_up;
		logic [C_W-1:0] below_dn;
		logic [C_W-1:0] above_up;
		logic [C_W-1:0] above_dn;
	} sweep_t;

	function automatic logic [COST_W-1:0] sweep_cost(input logic [C_W-1:0] c,
		input logic up, input sweep_t s);
		logic [C_W-1:0]    hi;
		logic [C_W-1:0]    lo;
		logic [COST_W-1:0] c_e;
		logic [COST_W-1:0] hi_e;
		logic [COST_W-1:0] lo_e;
		logic [COST_W-1:0] bu_e;
		logic [COST_W-1:0] ad_e;
		logic [COST_W-1:0] t;
		logic [COST_W-1:0] cost;
		hi = s.in_hi;
		if (s.above_up > hi) hi = s.above_up;
		if (s.above_dn > hi) hi = s.above_dn;
		lo = s.in_lo;
		if (s.below_up < lo) lo = s.below_up;
		if (s.below_dn < lo) lo = s.below_dn;
		c_e  = COST_W'(c);
		hi_e = COST_W'(hi);
		lo_e = COST_W'(lo);
		bu_e = COST_W'(s.below_up);
		ad_e = COST_W'(s.above_dn);
		if (up) begin
			if (hi <= c) begin
				cost = COST_W'(NO_WAY_COST);
			end else begin
				t = hi_e - c_e;
				if (lo >= c) begin
					cost = (s.above_dn == '0) ? t : t + hi_e - ad_e;
				end else begin
					t = (t << 1) + c_e - lo_e;
					cost = (s.below_up == FLOOR_NONE) ? t : t + bu_e - lo_e;
				end
			end
		end else begin
			if (lo >= c) begin
				cost = COST_W'(NO_WAY_COST);
			end else begin
				t = c_e - lo_e;
				if (hi <= c) begin
					cost = (s.below_up == FLOOR_NONE) ? t : t + bu_e - lo_e;
				end else begin
					t = (t << 1) + hi_e - c_e;
					cost = (s.above_dn == '0) ? t : t + hi_e - ad_e;
				end
			end
		end
		return cost;
	endfunction

endpackage

// File: design/elevator_fastest_response_dispatch.sv
// elevator dispatcher: call registers, floor scan, cost compare and move decision
// depends on efrd_pkg
`timescale 1ns / 1ps

// usage
// - request: start with mode and request_floor, taken at a clock edge where busy is low
// - button presses (car, hall up, hall down) are recorded in the taking cycle, busy stays
//   low and no result follows
// - a tick raises busy and gives exactly one result: done high for one cycle with
//   next_floor, action and going_up; busy is low again in that cycle
// - a tick is answered from the check state when idle or serving a car call or a
//   same-direction hall call; a move, or an opposite hall call served after weighing,
//   passes through the scan, cost, multiply and decide states; an opposite hall call at
//   the car floor weighed first and followed by a move runs scan and cost passes twice
// - each cost evaluation is one scan of the call bits, one floor per cycle, followed by
//   two passes through one shared cost and weight-multiply unit
// - keep_weight and turn_weight are written through cfg_we, cfg_index, cfg_data with no
//   wait states; the user must write them only while the block is idle, it does not enforce this
// - reset: no calls, car at floor 1 heading up, weights 5 and 6
// - the receiver cannot stall, results must be taken in their done cycle
module elevator_fastest_response_dispatch
	import efrd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [FLOOR_W-1:0]  request_floor,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [WEIGHT_W-1:0] cfg_data,
	output logic                done,
	output logic [FLOOR_W-1:0]  next_floor,
	output logic [1:0]          action,
	output logic                going_up
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CHECK  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_COST   = 6'b001000,
		ST_MUL    = 6'b010000,
		ST_DECIDE = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [FLOORS-1:0]    car_calls_q, up_calls_q, dn_calls_q;
	logic [FLOOR_W-1:0]   car_floor_q;
	logic                 dir_up_q;
	logic [DEF_W-1:0]     deferred_q;
	logic [WEIGHT_W-1:0]  keep_w_q, turn_w_q;
	logic                 phase_stop_q, phase_stop_d;
	logic                 pass_turn_q;
	logic                 done_q;
	logic [FLOOR_W-1:0]   next_floor_q;
	action_t              action_q;
	logic                 going_up_q;
	logic [C_W-1:0]       c_q, c_d;
	logic [IDX_W-1:0]     idx_q;
	sweep_t               summary_q;
	logic [COST_W-1:0]    cost_q;
	logic [PROD_W-1:0]    keep_q, turn_q;

	logic [FLOORS-1:0]    here_mask, req_mask;
	logic [FLOORS-1:0]    clr_car, clr_up, clr_dn, set_car, set_up, set_dn;
	logic                 pending;
	logic                 finish, move, scan_clr;
	action_t              fin_act;
	logic                 step_up;
	logic [FLOOR_W-1:0]   moved_floor;
	logic [C_W-1:0]       scan_floor;
	logic [COST_W-1:0]    cost_now;
	logic [PROD_W-1:0]    prod;
	logic                 press_take, press_ok, press_here;
	logic [C_W-1:0]       floor_c;

	assign busy       = (state_q != ST_IDLE);
	assign here_mask  = {{(FLOORS-1){1'b0}}, 1'b1} << (car_floor_q - FLOOR_W'(1));
	assign req_mask   = {{(FLOORS-1){1'b0}}, 1'b1} << (request_floor - FLOOR_W'(1));
	assign pending    = (|car_calls_q) | (|up_calls_q) | (|dn_calls_q) | (|deferred_q);
	assign floor_c    = C_W'(car_floor_q);
	assign scan_floor = C_W'(idx_q) + C_W'(1);

	// shared unit: cost of the selected direction, then its weighting
	assign cost_now = sweep_cost(c_q, pass_turn_q ? !dir_up_q : dir_up_q, summary_q);
	assign prod     = PROD_W'(cost_q) * PROD_W'(pass_turn_q ? turn_w_q : keep_w_q);

	assign step_up = (keep_q < turn_q) ? dir_up_q : !dir_up_q;
	always_comb begin
		if (step_up) begin
			moved_floor = (car_floor_q < FLOOR_W'(FLOORS)) ? car_floor_q + FLOOR_W'(1)
				: car_floor_q;
		end else begin
			moved_floor = (car_floor_q > FLOOR_W'(1)) ? car_floor_q - FLOOR_W'(1)
				: car_floor_q;
		end
	end

	assign press_take = start && (state_q == ST_IDLE) && (mode != MODE_TICK);
	assign press_ok   = (request_floor >= FLOOR_W'(1)) && (request_floor <= FLOOR_W'(FLOORS))
		&& !((mode == MODE_HALL_UP) && (request_floor == FLOOR_W'(FLOORS)))
		&& !((mode == MODE_HALL_DN) && (request_floor == FLOOR_W'(1)));
	assign press_here = (request_floor == car_floor_q);

	always_comb begin
		state_d      = state_q;
		phase_stop_d = phase_stop_q;
		c_d          = c_q;
		finish       = 1'b0;
		move         = 1'b0;
		scan_clr     = 1'b0;
		fin_act      = ACT_MOVE;
		clr_car      = '0;
		clr_up       = '0;
		clr_dn       = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && (mode == MODE_TICK)) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!pending) begin
					finish  = 1'b1;
					fin_act = ACT_IDLE;
				end else if (|(car_calls_q & here_mask)) begin
					finish  = 1'b1;
					fin_act = ACT_SERVE;
					clr_car = here_mask;
				end else if (dir_up_q && (|(up_calls_q & here_mask))) begin
					finish  = 1'b1;
					fin_act = ACT_SERVE;
					clr_up  = here_mask;
				end else if (!dir_up_q && (|(dn_calls_q & here_mask))) begin
					finish  = 1'b1;
					fin_act = ACT_SERVE;
					clr_dn  = here_mask;
				end else if (|((up_calls_q | dn_calls_q) & here_mask)) begin
					// opposite hall call here: weigh costs one floor ahead
					phase_stop_d = 1'b1;
					c_d          = dir_up_q ? floor_c + C_W'(1) : floor_c - C_W'(1);
					scan_clr     = 1'b1;
					state_d      = ST_SCAN;
				end else begin
					phase_stop_d = 1'b0;
					c_d          = floor_c;
					scan_clr     = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == IDX_W'(FLOORS - 1)) state_d = ST_COST;
			end
			ST_COST: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = pass_turn_q ? ST_DECIDE : ST_COST;
			end
			ST_DECIDE: begin
				if (phase_stop_q) begin
					if (keep_q > turn_q) begin
						finish  = 1'b1;
						fin_act = ACT_SERVE;
						clr_up  = here_mask;
						clr_dn  = here_mask;
					end else begin
						phase_stop_d = 1'b0;
						c_d          = floor_c;
						scan_clr     = 1'b1;
						state_d      = ST_SCAN;
					end
				end else begin
					finish  = 1'b1;
					move    = 1'b1;
					fin_act = ACT_MOVE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) state_d = ST_IDLE;
	end

	// presses away from the car floor set call bits, deferred ones merge after the tick
	always_comb begin
		set_car = '0;
		set_up  = '0;
		set_dn  = '0;
		if (press_take && press_ok && !press_here) begin
			case (mode)
				MODE_CAR:     set_car = req_mask;
				MODE_HALL_UP: set_up  = req_mask;
				MODE_HALL_DN: set_dn  = req_mask;
				default:      set_car = '0;
			endcase
		end
		if (finish) begin
			if (deferred_q[0]) set_car = set_car | here_mask;
			if (deferred_q[1]) set_up  = set_up | here_mask;
			if (deferred_q[2]) set_dn  = set_dn | here_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			car_calls_q  <= '0;
			up_calls_q   <= '0;
			dn_calls_q   <= '0;
			car_floor_q  <= FLOOR_W'(1);
			dir_up_q     <= 1'b1;
			deferred_q   <= '0;
			keep_w_q     <= KEEP_RESET;
			turn_w_q     <= TURN_RESET;
			phase_stop_q <= 1'b0;
			pass_turn_q  <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			phase_stop_q <= phase_stop_d;
			done_q       <= finish;
			car_calls_q  <= (car_calls_q & ~clr_car) | set_car;
			up_calls_q   <= (up_calls_q & ~clr_up) | set_up;
			dn_calls_q   <= (dn_calls_q & ~clr_dn) | set_dn;
			if (finish) begin
				deferred_q <= '0;
			end else if (press_take && press_ok && press_here) begin
				deferred_q <= deferred_q | (DEF_W'(1) << mode);
			end
			if (move) begin
				car_floor_q <= moved_floor;
				dir_up_q    <= step_up;
			end
			if (scan_clr) begin
				pass_turn_q <= 1'b0;
			end else if (state_q == ST_MUL) begin
				pass_turn_q <= !pass_turn_q;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEEP: keep_w_q <= cfg_data;
					CFG_TURN: turn_w_q <= cfg_data;
					default:  keep_w_q <= keep_w_q;
				endcase
			end
		end
	end

	// datapath registers of the scan and the shared unit
	always_ff @(posedge clk) begin
		c_q <= c_d;
		if (scan_clr) begin
			idx_q              <= '0;
			summary_q.in_lo    <= FLOOR_NONE;
			summary_q.in_hi    <= '0;
			summary_q.below_up <= FLOOR_NONE;
			summary_q.below_dn <= FLOOR_NONE;
			summary_q.above_up <= '0;
			summary_q.above_dn <= '0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + IDX_W'(1);
			if (car_calls_q[idx_q]) begin
				if (summary_q.in_lo == FLOOR_NONE) summary_q.in_lo <= scan_floor;
				summary_q.in_hi <= scan_floor;
			end
			if (scan_floor < c_q) begin
				if (up_calls_q[idx_q]) summary_q.below_up <= scan_floor;
				if (dn_calls_q[idx_q]) summary_q.below_dn <= scan_floor;
			end
			if (scan_floor > c_q) begin
				if (up_calls_q[idx_q]) summary_q.above_up <= scan_floor;
				if (dn_calls_q[idx_q]) summary_q.above_dn <= scan_floor;
			end
		end
		if (state_q == ST_COST) cost_q <= cost_now;
		if (state_q == ST_MUL) begin
			if (pass_turn_q) turn_q <= prod;
			else keep_q <= prod;
		end
		if (finish) begin
			next_floor_q <= move ? moved_floor : car_floor_q;
			action_q     <= fin_act;
			going_up_q   <= move ? step_up : dir_up_q;
		end
	end

	assign done       = done_q;
	assign next_floor = next_floor_q;
	assign action     = action_q;
	assign going_up   = going_up_q;

endmodule

// File: design/efrd_checker.sv
// port-level checks on the elevator dispatcher request and result timing
// depends on efrd_pkg; bound to elevator_fastest_response_dispatch
`timescale 1ns / 1ps

module efrd_checker
	import efrd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] mode,
	input logic       done
);

	// a result closes a tick, so the block is free again in that cycle
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a tick in progress");

	a_tick_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_TICK) |=> busy)
		else $error("tick request did not start work");

	a_press_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode != MODE_TICK) |=> (!busy && !done))
		else $error("button request caused work or a result");

endmodule

bind elevator_fastest_response_dispatch efrd_checker u_efrd_checker (.*);

// File: dv/tb_elevator_fastest_response_dispatch.sv
// self-checking testbench for elevator_fastest_response_dispatch
// depends on efrd_pkg and the dispatcher rtl; predicts every tick result in-line
`timescale 1ns / 1ps

module tb_elevator_fastest_response_dispatch;
	import efrd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 2 * FLOORS + 20;

	typedef struct packed {
		mode_t              kind;
		logic [FLOOR_W-1:0] floor;
	} press_t;

	typedef struct packed {
		logic [FLOOR_W-1:0] floor;
		action_t            act;
		logic               up;
	} stop_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          mode = MODE_CAR;
	logic [FLOOR_W-1:0]  request_floor = '0;
	logic                cfg_we = 1'b0;
	logic                cfg_index = CFG_KEEP;
	logic [WEIGHT_W-1:0] cfg_data = '0;
	logic                done;
	logic [FLOOR_W-1:0]  next_floor;
	logic [1:0]          action;
	logic                going_up;

	// predictor state
	logic [FLOORS-1:0]   cab_req;
	logic [FLOORS-1:0]   hall_up;
	logic [FLOORS-1:0]   hall_dn;
	int                  cab_floor;
	bit                  dir_up;
	logic [2:0]          held_here;
	int                  w_keep;
	int                  w_turn;

	press_t              request_queue[$];
	stop_t               tick_results[$];
	int                  gap_pct;
	bit                  taken;
	int                  mismatches;
	int                  cycles;

	elevator_fastest_response_dispatch u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.request_floor(request_floor),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.next_floor   (next_floor),
		.action       (action),
		.going_up     (going_up)
	);

	always #5 clk = ~clk;

	// travel length to answer every call when first heading one way from floor c
	function automatic int route_cost(int c, bit up);
		int none, in_hi, in_lo, bu, bd, au, ad, hi, lo, t, i;
		none = FLOORS + 1;
		in_hi = 0;
		in_lo = none;
		bu = none;
		bd = none;
		au = 0;
		ad = 0;
		for (i = 1; i <= FLOORS; i++) begin
			if (cab_req[i-1]) begin
				if (i < in_lo) in_lo = i;
				if (i > in_hi) in_hi = i;
			end
			if (i < c) begin
				if (hall_up[i-1]) bu = i;
				if (hall_dn[i-1]) bd = i;
			end
			if (i > c) begin
				if (hall_up[i-1]) au = i;
				if (hall_dn[i-1]) ad = i;
			end
		end
		hi = in_hi;
		if (au > hi) hi = au;
		if (ad > hi) hi = ad;
		lo = in_lo;
		if (bu < lo) lo = bu;
		if (bd < lo) lo = bd;
		if (up) begin
			if (hi <= c) return NO_WAY_COST;
			t = hi - c;
			if (lo >= c) return (ad == 0) ? t : t + hi - ad;
			t = 2 * t + c - lo;
			return (bu == none) ? t : t + bu - lo;
		end
		if (lo >= c) return NO_WAY_COST;
		t = c - lo;
		if (hi <= c) return (bu == none) ? t : t + bu - lo;
		t = 2 * t + hi - c;
		return (ad == 0) ? t : t + hi - ad;
	endfunction

	task automatic take_request(mode_t m, logic [FLOOR_W-1:0] rf);
		int rq, f, d, nf, keep_cost, turn_cost;
		action_t act;
		stop_t res;
		rq = int'(rf);
		f = cab_floor;
		d = dir_up ? 1 : -1;
		if (m != MODE_TICK) begin
			if (rq < 1 || rq > FLOORS) return;
			if (m == MODE_HALL_UP && rq == FLOORS) return;
			if (m == MODE_HALL_DN && rq == 1) return;
			if (rq == f) held_here[int'(m)] = 1'b1;
			else if (m == MODE_CAR) cab_req[rq-1] = 1'b1;
			else if (m == MODE_HALL_UP) hall_up[rq-1] = 1'b1;
			else hall_dn[rq-1] = 1'b1;
			return;
		end
		if ((cab_req | hall_up | hall_dn) == '0 && held_here == '0) begin
			act = ACT_IDLE;
		end else begin
			act = ACT_MOVE;
			if (cab_req[f-1]) begin
				cab_req[f-1] = 1'b0;
				act = ACT_SERVE;
			end else if (dir_up && hall_up[f-1]) begin
				hall_up[f-1] = 1'b0;
				act = ACT_SERVE;
			end else if (!dir_up && hall_dn[f-1]) begin
				hall_dn[f-1] = 1'b0;
				act = ACT_SERVE;
			end else if (hall_up[f-1] || hall_dn[f-1]) begin
				// lone opposite hall call: answer it only if turning here is cheaper
				keep_cost = route_cost(f + d, dir_up) * w_keep;
				turn_cost = route_cost(f + d, !dir_up) * w_turn;
				if (keep_cost > turn_cost) begin
					hall_up[f-1] = 1'b0;
					hall_dn[f-1] = 1'b0;
					act = ACT_SERVE;
				end
			end
			if (act == ACT_MOVE) begin
				keep_cost = route_cost(f, dir_up) * w_keep;
				turn_cost = route_cost(f, !dir_up) * w_turn;
				if (keep_cost >= turn_cost) d = -d;
				nf = f + d;
				if (nf < 1) nf = 1;
				if (nf > FLOORS) nf = FLOORS;
				cab_floor = nf;
				dir_up = (d > 0);
			end
		end
		// presses at the old car floor join the call bits after the tick
		if (held_here[0]) cab_req[f-1] = 1'b1;
		if (held_here[1]) hall_up[f-1] = 1'b1;
		if (held_here[2]) hall_dn[f-1] = 1'b1;
		held_here = '0;
		res.floor = FLOOR_W'(cab_floor);
		res.act = act;
		res.up = dir_up;
		tick_results.push_back(res);
	endtask

	// sample side: check finished ticks, then record the request taken at this edge
	always @(posedge clk) begin
		stop_t want;
		if (arst_n && done) begin
			if (tick_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result floor=%0d action=%0d up=%0d",
						next_floor, action, going_up);
			end else begin
				want = tick_results.pop_front();
				if (next_floor !== want.floor || action !== want.act ||
						going_up !== want.up) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected floor=%0d action=%0d up=%0d, got %0d %0d %0d",
							want.floor, want.act, want.up, next_floor, action, going_up);
				end
			end
		end
		taken = arst_n && start && !busy;
		if (taken) take_request(mode_t'(mode), request_floor);
	end

	always @(negedge clk) begin
		press_t nxt;
		if (!start || taken) begin
			if (request_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				nxt = request_queue.pop_front();
				start <= 1'b1;
				mode <= nxt.kind;
				request_floor <= nxt.floor;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL elevator_fastest_response_dispatch");
			$finish;
		end
	end

	task automatic add_request(mode_t m, int rf);
		press_t p;
		p.kind = m;
		p.floor = FLOOR_W'(rf);
		request_queue.push_back(p);
	endtask

	// bursts of presses followed by runs of ticks, now and then a long run to empty out
	task automatic queue_traffic(int n);
		int cnt, k, rf;
		mode_t m;
		cnt = 0;
		while (cnt < n) begin
			repeat ($urandom_range(0, 4)) begin
				m = mode_t'($urandom_range(0, 2));
				rf = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
					: $urandom_range(1, FLOORS);
				add_request(m, rf);
				if (rf >= 1 && rf <= FLOORS && !(m == MODE_HALL_UP && rf == FLOORS) &&
						!(m == MODE_HALL_DN && rf == 1))
					cnt++;
			end
			k = ($urandom_range(0, 9) == 0) ? 3 * FLOORS : $urandom_range(1, 8);
			repeat (k) add_request(MODE_TICK, $urandom_range(0, 15));
			cnt += k;
		end
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		while (request_queue.size() != 0 || start || busy || tick_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_weight(logic idx, int v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = WEIGHT_W'(v);
		if (idx == CFG_KEEP) w_keep = v;
		else w_turn = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int keep_tab[7];
		int turn_tab[7];
		int p;
		keep_tab = '{5, 1, 15, 15, 0, 1, 0};
		turn_tab = '{6, 15, 1, 15, 7, 1, 0};
		cab_req = '0;
		hall_up = '0;
		hall_dn = '0;
		cab_floor = 1;
		dir_up = 1'b1;
		held_here = '0;
		w_keep = 5;
		w_turn = 6;
		gap_pct = 22;
		mismatches = 0;
		cycles = 0;
		taken = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed opening: idle tick, deferred presses, ignored presses, then a busy sweep
		add_request(MODE_TICK, 0);
		add_request(MODE_CAR, 1);
		add_request(MODE_TICK, 15);
		add_request(MODE_HALL_UP, FLOORS);
		add_request(MODE_HALL_DN, 1);
		add_request(MODE_CAR, 0);
		add_request(MODE_CAR, 15);
		add_request(MODE_HALL_UP, 10);
		add_request(MODE_HALL_DN, 2);
		add_request(MODE_HALL_UP, 2);
		add_request(MODE_TICK, 2);
		add_request(MODE_CAR, FLOORS);
		add_request(MODE_HALL_UP, 1);
		add_request(MODE_HALL_DN, FLOORS);
		add_request(MODE_HALL_UP, 5);
		add_request(MODE_HALL_DN, 5);
		add_request(MODE_HALL_DN, 4);
		add_request(MODE_HALL_UP, 4);
		repeat (8) add_request(MODE_TICK, 8);

		for (p = 0; p < 7; p++) begin
			if (p > 0) begin
				wait_quiet();
				if (p == 6) begin
					keep_tab[p] = $urandom_range(1, 15);
					turn_tab[p] = $urandom_range(1, 15);
				end
				write_weight(CFG_KEEP, keep_tab[p]);
				write_weight(CFG_TURN, turn_tab[p]);
			end
			gap_pct = (p < 3) ? 22 : (p < 5) ? 64 : 0;
			queue_traffic((p == 4) ? 100 : 290);
		end
		wait_quiet();

		if (mismatches == 0 && tick_results.size() == 0)
			$display("PASS elevator_fastest_response_dispatch");
		else
			$display("FAIL elevator_fastest_response_dispatch");
		$finish;
	end

endmodule

// File: files.f
design/efrd_pkg.sv
design/elevator_fastest_response_dispatch.sv
design/efrd_checker.sv
dv/tb_elevator_fastest_response_dispatch.sv
